// File: hdl/serial_frame_builder_crc16_top_defines.svh
// Assertion helpers for the frame builder serializer.
`ifndef SERIAL_FRAME_BUILDER_CRC16_TOP_DEFINES_SVH
`define SERIAL_FRAME_BUILDER_CRC16_TOP_DEFINES_SVH

// Checked on every rising edge while reset is released.
`define SFB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SFB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/sfb_pkg.sv
package sfb_pkg;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_BODY   = 2'd1,
    OP_ACK    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic {
    KIND_HDR  = 1'b0,
    KIND_BODY = 1'b1
  } cmd_kind_e;

  // One queued job for the serializer.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  start;
    logic [15:0] seq;
    logic [15:0] flen;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'h1021;
  localparam logic [7:0]  StartReset   = 8'h02;

  // Byte positions inside a header run and inside a closing body run.
  localparam logic [2:0] PosStart   = 3'd0;
  localparam logic [2:0] PosSeqHi   = 3'd1;
  localparam logic [2:0] PosSeqLo   = 3'd2;
  localparam logic [2:0] PosLenHi   = 3'd3;
  localparam logic [2:0] PosLenLo   = 3'd4;
  localparam logic [2:0] PosCmd     = 3'd5;
  localparam logic [2:0] PosData    = 3'd0;
  localparam logic [2:0] PosCrcHi   = 3'd1;
  localparam logic [2:0] PosCrcLo   = 3'd2;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: hdl/serial_frame_builder_crc16_top.sv
// Channel  Dir  Handshake       Fields (lowest bit up)
// s_axis   in   tvalid/tready   tdata data_byte[7:0] frame_length[23:8]; tuser op; tlast last
// m_axis   out  tvalid/tready   tdata out_byte[7:0]; tuser end_of_frame; tlast last_of_run
// cfg      in   cfg_we_i        cfg_wdata_i start_byte[7:0]
//
// The front end takes one input transfer per cycle while the job queue has room;
// acknowledge and clear items end there and cause no output. The serializer sends
// one byte per cycle unless stalled: one for a body byte, three for a closing body byte,
// six for a header. A job passes through the queue before its first byte is registered.
// Output back-pressure stalls only the serializer until the queue fills.
// Reset empties the queue, presets the checksum, zeroes the sequence and loads start byte 0x02.
module serial_frame_builder_crc16_top #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: start byte, written whenever cfg_we_i is high.
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // data_byte[7:0], frame_length[23:8]
  input  logic [1:0]  s_axis_tuser_i,  // op[1:0]
  input  logic        s_axis_tlast_i,  // last
  // Output byte stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // out_byte[7:0]
  output logic        m_axis_tuser_o,  // end_of_frame
  output logic        m_axis_tlast_o   // last_of_run
);

  // Jobs travel from the classifier to the serializer through a short queue.
  sfb_pkg::fifo_stat_t stat;
  sfb_pkg::cmd_t       push_cmd, pop_cmd;
  logic                push, pop;

  sfb_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (s_axis_tvalid_i),
    .in_ready_o        (s_axis_tready_o),
    .in_op_i           (s_axis_tuser_i),
    .in_data_byte_i    (s_axis_tdata_i[7:0]),
    .in_frame_length_i (s_axis_tdata_i[23:8]),
    .in_last_i         (s_axis_tlast_i),
    .stat_i            (stat),
    .push_o            (push),
    .push_cmd_o        (push_cmd)
  );

  sfb_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .stat_o     (stat),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd)
  );

  // The serializer walks each job byte by byte and keeps the running checksum.
  sfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!stat.empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_eof_o   (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// File: hdl/sfb_fifo.sv
module sfb_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sfb_pkg::cmd_t       push_cmd_i,
  output sfb_pkg::fifo_stat_t stat_o,
  input  logic                pop_i,
  output sfb_pkg::cmd_t       pop_cmd_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  sfb_pkg::cmd_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign stat_o.full  = (count_q == CW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: hdl/sfb_front.sv
module sfb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          in_op_i,
  input  logic [7:0]          in_data_byte_i,
  input  logic [15:0]         in_frame_length_i,
  input  logic                in_last_i,
  input  sfb_pkg::fifo_stat_t stat_i,
  output logic                push_o,
  output sfb_pkg::cmd_t       push_cmd_o
);

  logic [7:0]  start_q;
  logic [15:0] seq_q, seq_d;
  logic        in_frame_q, in_frame_d;
  logic        accept;
  logic        push;

  assign in_ready_o = !stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    seq_d      = seq_q;
    in_frame_d = in_frame_q;
    push       = 1'b0;
    push_cmd_o = '{kind: sfb_pkg::KIND_BODY, start: start_q, seq: seq_q,
                   flen: in_frame_length_i, data: in_data_byte_i, last: in_last_i};
    case (sfb_pkg::op_e'(in_op_i))
      sfb_pkg::OP_HEADER: begin
        push_cmd_o.kind = sfb_pkg::KIND_HDR;
        push            = 1'b1;
        in_frame_d      = 1'b1;
      end
      sfb_pkg::OP_BODY: begin
        // Bytes outside an open frame are dropped.
        push = in_frame_q;
        if (in_frame_q && in_last_i) begin
          in_frame_d = 1'b0;
        end
      end
      sfb_pkg::OP_ACK: begin
        seq_d = seq_q + 16'd1;
      end
      sfb_pkg::OP_CLEAR: begin
        seq_d = '0;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign push_o = accept && push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= sfb_pkg::StartReset;
      seq_q      <= '0;
      in_frame_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
      if (accept) begin
        seq_q      <= seq_d;
        in_frame_q <= in_frame_d;
      end
    end
  end

endmodule

// File: hdl/sfb_back.sv
`include "serial_frame_builder_crc16_top_defines.svh"

module sfb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  sfb_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_eof_o,
  output logic          out_last_o
);

  logic [2:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, byte_sel;
  logic        out_eof_q, out_last_q;
  logic        eof_sel, final_sel;
  logic        advance;

  assign advance = cmd_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    byte_sel  = cmd_i.data;
    eof_sel   = 1'b0;
    final_sel = 1'b0;
    crc_d     = crc_q;
    case (cmd_i.kind)
      sfb_pkg::KIND_HDR: begin
        case (pos_q)
          sfb_pkg::PosStart: byte_sel = cmd_i.start;
          sfb_pkg::PosSeqHi: byte_sel = cmd_i.seq[15:8];
          sfb_pkg::PosSeqLo: byte_sel = cmd_i.seq[7:0];
          sfb_pkg::PosLenHi: byte_sel = cmd_i.flen[15:8];
          sfb_pkg::PosLenLo: byte_sel = cmd_i.flen[7:0];
          default: begin
            byte_sel  = cmd_i.data;
            final_sel = 1'b1;
          end
        endcase
        // The start byte restarts the checksum; the rest of the header feeds it.
        crc_d = (pos_q == sfb_pkg::PosStart) ? sfb_pkg::CrcInit
                                             : sfb_pkg::crc_byte(crc_q, byte_sel);
      end
      default: begin
        case (pos_q)
          sfb_pkg::PosData: begin
            byte_sel  = cmd_i.data;
            crc_d     = sfb_pkg::crc_byte(crc_q, cmd_i.data);
            final_sel = !cmd_i.last;
          end
          sfb_pkg::PosCrcHi: byte_sel = crc_q[15:8];
          default: begin
            byte_sel  = crc_q[7:0];
            eof_sel   = 1'b1;
            final_sel = 1'b1;
          end
        endcase
      end
    endcase
  end

  assign pop_o = advance && final_sel;
  assign pos_d = final_sel ? '0 : pos_q + 3'd1;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= sfb_pkg::CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        pos_q <= pos_d;
        crc_q <= crc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= byte_sel;
      out_eof_q  <= eof_sel;
      out_last_q <= final_sel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_eof_o   = out_eof_q;
  assign out_last_o  = out_last_q;

  `SFB_ASSERT(a_eof_ends_run, clk_i, rst_ni, (out_valid_q && out_eof_q) |-> out_last_q, "frame end without run end")
  `SFB_ASSERT(a_pos_range, clk_i, rst_ni, pos_q <= sfb_pkg::PosCmd, "serializer position out of range")
  `SFB_ASSERT(a_mid_run_has_cmd, clk_i, rst_ni, (pos_q != '0) |-> cmd_valid_i, "job left the queue mid run")
  `SFB_ASSERT_ALWAYS(a_no_pop_empty, clk_i, pop_o |-> cmd_valid_i, "pop from empty queue")

endmodule
